### hdl/dfi_pkg.sv
// ---------------------------------------------------------------------------
// dfi_pkg: shared definitions for the direct form I IIR filter
// Request codes, register indexes, fixed field widths and the control bundle
// that drives the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
package dfi_pkg;

    localparam int REQ_W      = 2;
    localparam int COEF_IDX_W = 4;
    localparam int TAP_CNT_W  = 4;
    localparam int CFG_IDX_W  = 4;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_NUM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WR_DEN = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_TAPS = 4'd1;

    typedef struct packed {
        logic clr;   // zero the accumulator
        logic vld;   // operands present this cycle
        logic sub;   // feedback term: subtract the product
    } mac_ctl_t;

endpackage

### hdl/dfi_mac.sv
// ---------------------------------------------------------------------------
// dfi_mac: shared multiply-accumulate unit
// One registered product per cycle, then a sign-extended add or subtract
// into a wide accumulator.
// ---------------------------------------------------------------------------
module dfi_mac
    import dfi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 24,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mac_ctl_t                      ctl_in,
    input  logic signed [COEF_WIDTH-1:0]  coef_in,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                          busy,
    output logic signed [ACC_WIDTH-1:0]   acc_out
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;

    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_next;
    logic                        prod_vld_reg;
    logic                        prod_sub_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] prod_ext;

    assign prod_next = coef_in * sample_in;
    assign prod_ext  = {{(ACC_WIDTH-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        prod_sub_reg <= ctl_in.sub;
        if (ctl_in.clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= prod_sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    assign busy    = prod_vld_reg;
    assign acc_out = acc_reg;

endmodule

### hdl/direct_form_iir_filter_unit.sv
// ---------------------------------------------------------------------------
// direct_form_iir_filter_unit: direct form I IIR filter
// Fixed-point IIR filter with coefficient writes and history clear through
// the request stream, tap counts through the configuration channel.
// ---------------------------------------------------------------------------
// A sample request keeps s_tready low from acceptance until its result is
// loaded into the output register, so no new sample is accepted while one is
// in progress, nor while the result waits for a free output register. The
// single multiply-accumulate unit handles one coefficient per cycle, and the
// read, multiply and accumulate pipeline drains before rounding. Coefficient
// writes and history clears are accepted only while idle and return no
// result. The output is rounded half up and saturated to the sample range;
// m_tuser flags clipping.
module direct_form_iir_filter_unit
    import dfi_pkg::*;
#(
    parameter int ORDER          = 8,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_WIDTH     = 24,
    parameter int COEF_FRAC_BITS = 18
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // sample_in, coef_index, coef_value (lowest bits first), zero padded
    input  logic [((SAMPLE_WIDTH+COEF_IDX_W+COEF_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic [REQ_W-1:0]           s_tuser,  // req_type
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,  // sample_out, zero padded
    output logic [0:0]                 m_tuser,  // saturated
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [TAP_CNT_W-1:0]       cfg_data
);

    localparam int TAPS   = ORDER + 1;
    localparam int ADDR_W = $clog2(TAPS);
    localparam int HIST_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int OUT_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int GUARD  = $clog2(2 * TAPS) + 1;
    localparam int WIDE_W = (COEF_WIDTH > COEF_FRAC_BITS) ? COEF_WIDTH : COEF_FRAC_BITS;
    localparam int ACC_W  = SAMPLE_WIDTH + WIDE_W + GUARD;

    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    // request fields
    logic [REQ_W-1:0]               s_req;
    logic signed [SAMPLE_WIDTH-1:0] s_sample;
    logic [COEF_IDX_W-1:0]          s_cidx;
    logic signed [COEF_WIDTH-1:0]   s_cval;
    logic                           s_acc;
    logic                           cidx_ok;
    logic [ADDR_W-1:0]              waddr;

    // control
    logic [1:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       k_reg, k_next;
    logic                    fb_phase_reg, fb_phase_next;
    logic [ADDR_W-1:0]       nb_last_reg, na_last_reg;
    logic [TAP_CNT_W-1:0]    num_taps_reg, den_taps_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;

    // coefficient stores and histories
    logic signed [COEF_WIDTH-1:0]   ff_mem [TAPS];
    logic signed [COEF_WIDTH-1:0]   fb_mem [TAPS];
    logic [TAPS-1:0]                ff_vld_reg, fb_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] pin_reg  [ORDER];
    logic signed [SAMPLE_WIDTH-1:0] pout_reg [ORDER];

    // read stage
    logic                           rd_vld_reg, rd_sub_reg, rd_fb_reg;
    logic                           ff_rdv_reg, fb_rdv_reg;
    logic signed [COEF_WIDTH-1:0]   ff_rd_reg, fb_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_samp_reg;
    logic signed [SAMPLE_WIDTH-1:0] issue_samp;
    logic [HIST_W-1:0]              hidx;
    logic signed [COEF_WIDTH-1:0]   mac_coef;
    mac_ctl_t                       mac_ctl;
    logic                           mac_busy;
    logic signed [ACC_W-1:0]        acc;

    // rounding and output
    logic signed [ACC_W-1:0]        rnd_sum, rnd_sh;
    logic                           sat_hi, sat_lo;
    logic [SAMPLE_WIDTH-1:0]        y_val;
    logic                           out_load;
    logic                           m_valid_reg;
    logic [SAMPLE_WIDTH-1:0]        m_data_reg;
    logic                           m_sat_reg;

    function automatic logic [ADDR_W-1:0] last_tap(input logic [TAP_CNT_W-1:0] r);
        logic [ADDR_W-1:0] res;
        if (r == '0) begin
            res = '0;
        end else if (32'(r) > TAPS) begin
            res = ADDR_W'(ORDER);
        end else begin
            res = ADDR_W'(r - 1'b1);
        end
        return res;
    endfunction

    assign s_req    = s_tuser;
    assign s_sample = s_tdata[SAMPLE_WIDTH-1:0];
    assign s_cidx   = s_tdata[SAMPLE_WIDTH+COEF_IDX_W-1:SAMPLE_WIDTH];
    assign s_cval   = s_tdata[SAMPLE_WIDTH+COEF_IDX_W+COEF_WIDTH-1:SAMPLE_WIDTH+COEF_IDX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cidx_ok  = (32'(s_cidx) <= ORDER);
    assign waddr    = ADDR_W'(s_cidx);

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg <= TAP_CNT_W'(1);
            den_taps_reg <= TAP_CNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NUM_TAPS: num_taps_reg <= cfg_data;
                CFG_DEN_TAPS: den_taps_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (s_acc && cidx_ok && s_req == REQ_WR_NUM) begin
            ff_mem[waddr] <= s_cval;
        end
        if (s_acc && cidx_ok && s_req == REQ_WR_DEN) begin
            fb_mem[waddr] <= s_cval;
        end
        ff_rd_reg <= ff_mem[k_reg];
        fb_rd_reg <= fb_mem[k_reg];
    end

    // unwritten coefficients read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_vld_reg <= '0;
            fb_vld_reg <= '0;
            ff_rdv_reg <= 1'b0;
            fb_rdv_reg <= 1'b0;
        end else begin
            if (s_acc && cidx_ok && s_req == REQ_WR_NUM) begin
                ff_vld_reg[waddr] <= 1'b1;
            end
            if (s_acc && cidx_ok && s_req == REQ_WR_DEN) begin
                fb_vld_reg[waddr] <= 1'b1;
            end
            ff_rdv_reg <= ff_vld_reg[k_reg];
            fb_rdv_reg <= fb_vld_reg[k_reg];
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        fb_phase_next = fb_phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_req == REQ_SAMPLE) begin
                    state_next    = ST_RUN;
                    k_next        = '0;
                    fb_phase_next = 1'b0;
                end
            end
            ST_RUN: begin
                if (!fb_phase_reg) begin
                    if (k_reg == nb_last_reg) begin
                        if (na_last_reg != '0) begin
                            fb_phase_next = 1'b1;
                            k_next        = ADDR_W'(1);
                        end else begin
                            state_next = ST_DRAIN;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    if (k_reg == na_last_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mac_busy) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            fb_phase_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            fb_phase_reg <= fb_phase_next;
            rd_vld_reg   <= (state_reg == ST_RUN);
        end
    end

    // per-sample operands, latched at acceptance
    always_ff @(posedge aclk) begin
        if (s_acc && s_req == REQ_SAMPLE) begin
            x_reg       <= s_sample;
            nb_last_reg <= last_tap(num_taps_reg);
            na_last_reg <= last_tap(den_taps_reg);
        end
        rd_samp_reg <= issue_samp;
        rd_sub_reg  <= fb_phase_reg;
        rd_fb_reg   <= fb_phase_reg;
    end

    assign hidx = HIST_W'(k_reg - 1'b1);

    always_comb begin
        if (fb_phase_reg) begin
            issue_samp = pout_reg[hidx];
        end else if (k_reg == '0) begin
            issue_samp = x_reg;
        end else begin
            issue_samp = pin_reg[hidx];
        end
    end

    always_comb begin
        if (rd_fb_reg) begin
            mac_coef = fb_rdv_reg ? fb_rd_reg : '0;
        end else begin
            mac_coef = ff_rdv_reg ? ff_rd_reg : '0;
        end
    end

    assign mac_ctl.clr = s_acc && (s_req == REQ_SAMPLE);
    assign mac_ctl.vld = rd_vld_reg;
    assign mac_ctl.sub = rd_sub_reg;

    dfi_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .ACC_WIDTH    (ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (mac_ctl),
        .coef_in   (mac_coef),
        .sample_in (rd_samp_reg),
        .busy      (mac_busy),
        .acc_out   (acc)
    );

    // round half up, then clip to the sample range
    assign rnd_sum = acc + $signed(RND_HALF);
    assign rnd_sh  = rnd_sum >>> COEF_FRAC_BITS;
    assign sat_hi  = !rnd_sh[ACC_W-1] && (|rnd_sh[ACC_W-1:SAMPLE_WIDTH-1]);
    assign sat_lo  = rnd_sh[ACC_W-1] && !(&rnd_sh[ACC_W-1:SAMPLE_WIDTH-1]);

    always_comb begin
        if (sat_hi) begin
            y_val = SMAX;
        end else if (sat_lo) begin
            y_val = SMIN;
        end else begin
            y_val = rnd_sh[SAMPLE_WIDTH-1:0];
        end
    end

    assign out_load = (state_reg == ST_FINAL) && (!m_valid_reg || m_tready);

    // histories: shift on a finished sample, clear on request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ORDER; i++) begin
                pin_reg[i]  <= '0;
                pout_reg[i] <= '0;
            end
        end else if (s_acc && s_req == REQ_CLEAR) begin
            for (int i = 0; i < ORDER; i++) begin
                pin_reg[i]  <= '0;
                pout_reg[i] <= '0;
            end
        end else if (out_load) begin
            pin_reg[0]  <= x_reg;
            pout_reg[0] <= $signed(y_val);
            for (int i = 1; i < ORDER; i++) begin
                pin_reg[i]  <= pin_reg[i-1];
                pout_reg[i] <= pout_reg[i-1];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= y_val;
            m_sat_reg  <= sat_hi || sat_lo;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);
    assign m_tuser  = m_sat_reg;

`ifndef SYNTHESIS
    a_sample_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == REQ_SAMPLE) |=> (state_reg == ST_RUN))
        else $error("sample transaction did not start the tap sequence");

    a_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (32'(k_reg) <= ORDER))
        else $error("tap counter beyond filter order");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!rd_vld_reg && !mac_busy))
        else $error("multiply-accumulate pipeline busy while idle");

    a_result_from_final: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_FINAL))
        else $error("result presented outside the final step");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: direct form I IIR filter unit
// Sends sample, coefficient-write and clear requests over the request stream
// and changes the tap counts between phases. Results are checked against a
// fixed-point filter model beside the unit, or against table values for
// typed rows. Random stalls on both streams and one long output hold-off.
// ---------------------------------------------------------------------------
module testbench;
    import dfi_pkg::*;

    localparam int ORDER        = 8;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 24;
    localparam int COEF_FRAC    = 18;
    localparam int S_TDATA_W    = ((SAMPLE_W + COEF_IDX_W + COEF_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 2 * ORDER + 6 + 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 103;
    localparam longint SMAX     = 32767;
    localparam longint SMIN     = -32768;

    typedef struct packed {
        logic [REQ_W-1:0]         kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COEF_IDX_W-1:0]    idx;
        logic signed [COEF_W-1:0] coef;
    } request_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sat;
    } filter_out_t;

    typedef struct packed {
        request_t    rq;
        logic        typed;
        filter_out_t out;
    } table_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [TAP_CNT_W-1:0]  cfg_data;

    // filter model state
    logic signed [COEF_W-1:0]   ff_coef [ORDER+1];
    logic signed [COEF_W-1:0]   fb_coef [ORDER+1];
    logic signed [SAMPLE_W-1:0] hist_x  [ORDER];
    logic signed [SAMPLE_W-1:0] hist_y  [ORDER];
    logic [TAP_CNT_W-1:0]       num_taps;
    logic [TAP_CNT_W-1:0]       den_taps;

    filter_out_t expected_outputs[$];
    table_row_t  directed_rows[$];
    int          mismatch_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_output = 1'b0;
    int          num_setting [N_PHASES] = '{0, 15, 9, 1, 9, 4, 0, 0};
    int          den_setting [N_PHASES] = '{0, 15, 9, 9, 1, 3, 0, 0};

    direct_form_iir_filter_unit #(
        .ORDER(ORDER),
        .SAMPLE_WIDTH(SAMPLE_W),
        .COEF_WIDTH(COEF_W),
        .COEF_FRAC_BITS(COEF_FRAC)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int tap_count(input logic [TAP_CNT_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > ORDER + 1)
            return ORDER + 1;
        return int'(r);
    endfunction

    task automatic filter_request(input request_t rq, output bit produces,
                                  output filter_out_t res);
        longint acc;
        longint y;
        int     nb;
        int     na;
        produces = 1'b0;
        res = '0;
        case (rq.kind)
            REQ_WR_NUM: begin
                if (rq.idx <= ORDER)
                    ff_coef[rq.idx] = rq.coef;
            end
            REQ_WR_DEN: begin
                if (rq.idx <= ORDER)
                    fb_coef[rq.idx] = rq.coef;
            end
            REQ_CLEAR: begin
                for (int k = 0; k < ORDER; k++) begin
                    hist_x[k] = '0;
                    hist_y[k] = '0;
                end
            end
            default: begin
                nb = tap_count(num_taps);
                na = tap_count(den_taps);
                acc = longint'(ff_coef[0]) * longint'(rq.sample);
                for (int k = 1; k < nb; k++)
                    acc += longint'(ff_coef[k]) * longint'(hist_x[k-1]);
                // a0 is implicit one, so feedback starts at a1
                for (int k = 1; k < na; k++)
                    acc -= longint'(fb_coef[k]) * longint'(hist_y[k-1]);
                y = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
                if (y > SMAX) begin
                    y = SMAX;
                    res.sat = 1'b1;
                end else if (y < SMIN) begin
                    y = SMIN;
                    res.sat = 1'b1;
                end
                // histories shift through all entries regardless of tap counts
                for (int k = ORDER - 1; k > 0; k--) begin
                    hist_x[k] = hist_x[k-1];
                    hist_y[k] = hist_y[k-1];
                end
                hist_x[0] = rq.sample;
                hist_y[0] = y[SAMPLE_W-1:0];
                res.sample = y[SAMPLE_W-1:0];
                produces = 1'b1;
            end
        endcase
    endtask

    function automatic int pick_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [COEF_W-1:0] random_coef();
        int          v;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            v = int'($urandom_range(0, 131071)) - 65536;
        else if (r < 8)
            v = int'($urandom_range(0, 524287)) - 262144;
        else
            v = int'($urandom());
        return v[COEF_W-1:0];
    endfunction

    function automatic request_t random_request();
        request_t    rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            rq.kind = REQ_SAMPLE;
        else if (pick < 83)
            rq.kind = REQ_WR_NUM;
        else if (pick < 96)
            rq.kind = REQ_WR_DEN;
        else
            rq.kind = REQ_CLEAR;
        if ($urandom_range(0, 9) == 0)
            rq.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else
            rq.sample = SAMPLE_W'($urandom());
        if ($urandom_range(0, 6) == 0)
            rq.idx = COEF_IDX_W'($urandom_range(ORDER + 1, 15));
        else
            rq.idx = COEF_IDX_W'($urandom_range(0, ORDER));
        rq.coef = random_coef();
        return rq;
    endfunction

    function automatic table_row_t row(input logic [REQ_W-1:0] kind, input int sample,
                                       input int idx, input int coef, input bit typed,
                                       input int out_sample, input bit out_sat);
        table_row_t r;
        r.rq.kind     = kind;
        r.rq.sample   = sample[SAMPLE_W-1:0];
        r.rq.idx      = idx[COEF_IDX_W-1:0];
        r.rq.coef     = coef[COEF_W-1:0];
        r.typed       = typed;
        r.out.sample  = out_sample[SAMPLE_W-1:0];
        r.out.sat     = out_sat;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_request(input request_t rq, input bit typed,
                                input filter_out_t typed_out);
        bit          produces;
        filter_out_t model_out;
        s_tdata  <= {{(S_TDATA_W - SAMPLE_W - COEF_IDX_W - COEF_W){1'b0}},
                     rq.coef, rq.idx, rq.sample};
        s_tuser  <= rq.kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        filter_request(rq, produces, model_out);
        if (produces)
            expected_outputs.push_back(typed ? typed_out : model_out);
        @(negedge aclk);
    endtask

    task automatic hold_input(input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[TAP_CNT_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_NUM_TAPS)
            num_taps = value[TAP_CNT_W-1:0];
        else if (idx == CFG_DEN_TAPS)
            den_taps = value[TAP_CNT_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every result, then let writes and clears settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // result stream ready
    initial begin : output_ready
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_output = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : output_check
        filter_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result sample_out=%0d saturated=%0b",
                         $realtime, $signed(m_tdata[SAMPLE_W-1:0]), m_tuser[0]);
            end else begin
                want = expected_outputs.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== want.sample) begin
                    mismatch_count++;
                    $display("%0t: sample_out expected %0d actual %0d", $realtime,
                             want.sample, $signed(m_tdata[SAMPLE_W-1:0]));
                end
                if (m_tuser[0] !== want.sat) begin
                    mismatch_count++;
                    $display("%0t: saturated expected %0b actual %0b", $realtime,
                             want.sat, m_tuser[0]);
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_SAMPLE;
        cfg_valid = 1'b0;
        cfg_index = CFG_NUM_TAPS;
        cfg_data  = '0;
        num_taps  = 4'd1;
        den_taps  = 4'd1;
        for (int k = 0; k <= ORDER; k++) begin
            ff_coef[k] = '0;
            fb_coef[k] = '0;
        end
        for (int k = 0; k < ORDER; k++) begin
            hist_x[k] = '0;
            hist_y[k] = '0;
        end

        // single taps from reset; Q6.18 one is 262144
        directed_rows.push_back(row(REQ_SAMPLE,  32767, 0,        0, 1,      0, 0));
        directed_rows.push_back(row(REQ_WR_NUM,      0, 0,   262144, 0,      0, 0));
        directed_rows.push_back(row(REQ_SAMPLE,  32767, 0,        0, 1,  32767, 0));
        directed_rows.push_back(row(REQ_SAMPLE, -32768, 0,        0, 1, -32768, 0));
        directed_rows.push_back(row(REQ_SAMPLE,      0, 0,        0, 1,      0, 0));
        directed_rows.push_back(row(REQ_WR_NUM,      0, 0,  8388607, 0,      0, 0));
        directed_rows.push_back(row(REQ_SAMPLE,  32767, 0,        0, 1,  32767, 1));
        directed_rows.push_back(row(REQ_SAMPLE, -32768, 0,        0, 1, -32768, 1));
        directed_rows.push_back(row(REQ_SAMPLE,      1, 0,        0, 1,     32, 0));
        directed_rows.push_back(row(REQ_WR_NUM,      0, 0, -8388608, 0,      0, 0));
        directed_rows.push_back(row(REQ_SAMPLE, -32768, 0,        0, 1,  32767, 1));
        directed_rows.push_back(row(REQ_SAMPLE,  32767, 0,        0, 1, -32768, 1));
        // index above the order: write dropped, b0 stays at its minimum
        directed_rows.push_back(row(REQ_WR_NUM,      0, 15,  262144, 0,      0, 0));
        directed_rows.push_back(row(REQ_SAMPLE,      1, 0,        0, 1,    -32, 0));
        // b0 = 0.5: exact halves round toward plus infinity
        directed_rows.push_back(row(REQ_WR_NUM,      0, 0,   131072, 0,      0, 0));
        directed_rows.push_back(row(REQ_SAMPLE,      1, 0,        0, 1,      1, 0));
        directed_rows.push_back(row(REQ_SAMPLE,     -1, 0,        0, 1,      0, 0));
        // a0 is stored but never used
        directed_rows.push_back(row(REQ_WR_DEN,      0, 0,  8388607, 0,      0, 0));
        directed_rows.push_back(row(REQ_WR_DEN,      0, 8, -8388608, 0,      0, 0));
        directed_rows.push_back(row(REQ_WR_NUM,      0, 8,  8388607, 0,      0, 0));
        directed_rows.push_back(row(REQ_WR_DEN,      0, 9,      100, 0,      0, 0));
        directed_rows.push_back(row(REQ_CLEAR,       0, 0,        0, 0,      0, 0));
        directed_rows.push_back(row(REQ_SAMPLE,      2, 0,        0, 1,      1, 0));
        directed_rows.push_back(row(REQ_WR_DEN,      0, 1,   262144, 0,      0, 0));
        directed_rows.push_back(row(REQ_SAMPLE,  -1234, 0,        0, 0,      0, 0));

        num_setting[6] = $urandom_range(0, 15);
        den_setting[6] = $urandom_range(0, 15);
        num_setting[7] = $urandom_range(2, 9);
        den_setting[7] = $urandom_range(2, 9);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            hold_input(pick_gap());
            send_request(directed_rows[i].rq, directed_rows[i].typed,
                         directed_rows[i].out);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_register(CFG_NUM_TAPS, num_setting[p]);
            write_register(CFG_DEN_TAPS, den_setting[p]);
            idle_on = (p != 3);
            // back up the result stream so the unit stalls its input
            if (p == 2)
                hold_output = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                hold_input(pick_gap());
                send_request(random_request(), 1'b0, '0);
            end
        end

        idle_on = 1'b1;
        drain();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/dfi_pkg.sv
hdl/dfi_mac.sv
hdl/direct_form_iir_filter_unit.sv
verif/testbench.sv
